>>> src/lapsh_pkg.sv
// ----------------------------------------------------------------------------
// lapsh_pkg
// shared widths, register indexes and the window word passed to the filter
// ----------------------------------------------------------------------------
`default_nettype none

package lapsh_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;
    localparam int LAP_W      = 12;
    localparam int SUM_W      = 12;
    localparam int WIN_N      = 9;
    localparam int CENTRE_TAP = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(256);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(256);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = HEIGHT_W'(4096);

    // floor(x / 9) = (x * RECIP_9) >> RECIP_SHIFT, exact for x below 2296
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(7282);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } cfg_idx_t;

    // one full 3x3 window plus where its centre sits
    typedef struct packed {
        logic [WIN_N-1:0][PIX_W-1:0] pix;
        logic [ROW_W-1:0]            row;
        logic [COL_W-1:0]            col;
        logic                        last;
    } win_t;

    typedef struct packed {
        logic [PIX_W-1:0] box_average;
        logic [LAP_W-1:0] laplacian_value;
        logic [PIX_W-1:0] sharpened;
        logic [ROW_W-1:0] centre_row;
        logic [COL_W-1:0] centre_col;
        logic             frame_last;
    } res_t;

endpackage

`default_nettype wire

>>> src/lapsh_line_mem.sv
// ----------------------------------------------------------------------------
// lapsh_line_mem
// two line stores side by side in one synchronous ram, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module lapsh_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = 16
) (
    input  wire logic          aclk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output      logic [DW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> src/lapsh_filter.sv
// ----------------------------------------------------------------------------
// lapsh_filter
// window sum and laplacian stage, then divide by nine, sharpen and hold
// ----------------------------------------------------------------------------
`default_nettype none

module lapsh_filter (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output      logic             in_ready,
    input  wire lapsh_pkg::win_t  in_win,
    output      logic             out_valid,
    input  wire logic             out_ready,
    output      lapsh_pkg::res_t  out_res
);

    localparam int LAP_INT_W = lapsh_pkg::SUM_W + 2;
    localparam int PROD_W    = lapsh_pkg::SUM_W + lapsh_pkg::RECIP_W;

    logic                              s1_valid_reg;
    logic [lapsh_pkg::SUM_W-1:0]       s1_sum_reg;
    logic [lapsh_pkg::PIX_W-1:0]       s1_centre_reg;
    logic signed [LAP_INT_W-1:0]       s1_lap_reg;
    logic [lapsh_pkg::ROW_W-1:0]       s1_row_reg;
    logic [lapsh_pkg::COL_W-1:0]       s1_col_reg;
    logic                              s1_last_reg;
    logic                              out_valid_reg;
    lapsh_pkg::res_t                   out_res_reg;

    logic [lapsh_pkg::SUM_W-1:0]       sum;
    logic signed [LAP_INT_W-1:0]       centre9;
    logic signed [LAP_INT_W-1:0]       lap;
    logic [PROD_W-1:0]                 prod;
    logic signed [LAP_INT_W-1:0]       sharp_raw;
    logic [lapsh_pkg::PIX_W-1:0]       sharp;
    logic                              out_take;
    logic                              s1_adv;

    always_comb begin
        sum = '0;
        for (int i = 0; i < lapsh_pkg::WIN_N; i++) begin
            sum = sum + lapsh_pkg::SUM_W'(in_win.pix[i]);
        end
    end

    // 9*centre - sum, which is 8*centre minus the neighbours
    assign centre9 = LAP_INT_W'({in_win.pix[lapsh_pkg::CENTRE_TAP], 3'b000})
                   + LAP_INT_W'(in_win.pix[lapsh_pkg::CENTRE_TAP]);
    assign lap     = centre9 - LAP_INT_W'(sum);

    assign out_take = !out_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && out_take;
    assign in_ready = !s1_valid_reg || out_take;

    assign prod      = PROD_W'(s1_sum_reg) * PROD_W'(lapsh_pkg::RECIP_9);
    assign sharp_raw = s1_lap_reg + LAP_INT_W'(s1_centre_reg);

    always_comb begin
        if (sharp_raw < 0) begin
            sharp = '0;
        end else if (sharp_raw > LAP_INT_W'(255)) begin
            sharp = '1;
        end else begin
            sharp = sharp_raw[lapsh_pkg::PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (out_take) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            s1_sum_reg    <= sum;
            s1_centre_reg <= in_win.pix[lapsh_pkg::CENTRE_TAP];
            s1_lap_reg    <= lap;
            s1_row_reg    <= in_win.row;
            s1_col_reg    <= in_win.col;
            s1_last_reg   <= in_win.last;
        end
        if (s1_adv) begin
            out_res_reg.box_average     <=
                prod[lapsh_pkg::RECIP_SHIFT +: lapsh_pkg::PIX_W];
            out_res_reg.laplacian_value <= s1_lap_reg[lapsh_pkg::LAP_W-1:0];
            out_res_reg.sharpened       <= sharp;
            out_res_reg.centre_row      <= s1_row_reg;
            out_res_reg.centre_col      <= s1_col_reg;
            out_res_reg.frame_last      <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

`default_nettype wire

>>> src/window_3x3_average_laplacian_sharpen_core.sv
// ----------------------------------------------------------------------------
// window_3x3_average_laplacian_sharpen_core
// 3x3 box average, laplacian and sharpening over a raster pixel stream
// ----------------------------------------------------------------------------
//
//  channel   dir   word                                   handshake
//  -------   ---   ------------------------------------   ---------------
//  s_axis    in    tdata[7:0] pixel                       tvalid / tready
//  m_axis    out   tdata: average, laplacian, sharpened,  tvalid / tready
//                  row, col; tlast = frame last
//  cfg       in    cfg_wr_index, cfg_wr_data              cfg_wr_en only
//
//  one pixel per clock sustained while m_tready stays high; an accepted pixel
//  passes stage 0 (line store read alongside), the sum/laplacian stage and
//  the divide/sharpen output register on its way to m_tvalid
//  the line store ram has one read and one write port; the write of a pixel
//  always lands before the next read of the same column, so no forwarding
//  reset clears counters and valid flags and loads 256 into both size registers;
//  ram and taps hold garbage until written, seen only by border pixels that are not emitted
//  a stall at m_tready backs up through the pipe; s_tready drops only when
//  every stage is full
//
`default_nettype none

module window_3x3_average_laplacian_sharpen_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    input  wire logic [7:0]                       s_tdata,   // [7:0] pixel

    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    // [7:0] box_average, [19:8] laplacian_value, [27:20] sharpened,
    // [39:28] centre_row, [49:40] centre_col, [55:50] zero
    output      logic [55:0]                      m_tdata,
    output      logic                             m_tlast,   // frame_last

    input  wire logic                             cfg_wr_en,
    input  wire logic [lapsh_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [lapsh_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WX   = 14;                 // room to compare against MAX_WIDTH
    localparam int PW   = lapsh_pkg::PIX_W;
    localparam int RW   = lapsh_pkg::ROW_W;
    localparam int MEMW = 2 * PW;             // {middle row, upper row}

    // ---------------- configuration ----------------
    logic [lapsh_pkg::WIDTH_W-1:0]  width_reg;
    logic [lapsh_pkg::HEIGHT_W-1:0] height_reg;
    logic                           cfg_hit;
    logic [WX-1:0]                  width_x;
    logic [WX-1:0]                  width_eff;
    logic [WX-1:0]                  width_m1;
    logic [lapsh_pkg::HEIGHT_W-1:0] height_eff;
    logic [lapsh_pkg::HEIGHT_W-1:0] height_m1;
    logic [CW-1:0]                  last_col;
    logic [RW-1:0]                  last_row;

    assign cfg_hit = cfg_wr_en
        && (cfg_wr_index == lapsh_pkg::CFG_IMAGE_WIDTH
            || cfg_wr_index == lapsh_pkg::CFG_IMAGE_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= lapsh_pkg::WIDTH_RESET;
            height_reg <= lapsh_pkg::HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                lapsh_pkg::CFG_IMAGE_WIDTH: begin
                    width_reg <= cfg_wr_data[lapsh_pkg::WIDTH_W-1:0];
                end
                lapsh_pkg::CFG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    // out-of-range sizes clamp to the legal window
    assign width_x = WX'(width_reg);
    always_comb begin
        if (width_x < WX'(3)) begin
            width_eff = WX'(3);
        end else if (width_x > WX'(MAX_WIDTH)) begin
            width_eff = WX'(MAX_WIDTH);
        end else begin
            width_eff = width_x;
        end
        if (height_reg < lapsh_pkg::HEIGHT_MIN) begin
            height_eff = lapsh_pkg::HEIGHT_MIN;
        end else if (height_reg > lapsh_pkg::HEIGHT_MAX) begin
            height_eff = lapsh_pkg::HEIGHT_MAX;
        end else begin
            height_eff = height_reg;
        end
    end

    assign width_m1  = width_eff - WX'(1);
    assign height_m1 = height_eff - lapsh_pkg::HEIGHT_W'(1);
    assign last_col  = width_m1[CW-1:0];
    assign last_row  = height_m1[RW-1:0];

    // ---------------- raster position of the next pixel ----------------
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic          s_take;

    assign s_take = s_tvalid && s_tready;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_take) begin
            if (col_reg == last_col) begin
                col_next = '0;
                row_next = (row_reg == last_row) ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
        // a write to the width or height register starts a new frame
        if (cfg_hit) begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- stage 0: pixel waits for its line store read ----------------
    logic          s0_valid_reg;
    logic [PW-1:0] s0_pix_reg;
    logic [CW-1:0] s0_col_reg;
    logic [RW-1:0] s0_row_reg;
    logic          s0_emit_reg;
    logic          s0_last_reg;
    logic          s0_adv;
    logic          flt_ready;

    // border pixels retire from stage 0 without touching the filter
    assign s0_adv   = s0_valid_reg && (!s0_emit_reg || flt_ready);
    assign s_tready = !s0_valid_reg || s0_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            s0_pix_reg  <= s_tdata;
            s0_col_reg  <= col_reg;
            s0_row_reg  <= row_reg;
            s0_emit_reg <= (col_reg >= CW'(2)) && (row_reg >= RW'(2));
            s0_last_reg <= (col_reg == last_col) && (row_reg == last_row);
        end
    end

    // ---------------- line stores ----------------
    logic [MEMW-1:0] mem_rd_data;
    logic [PW-1:0]   up_pix;
    logic [PW-1:0]   mid_pix;

    assign up_pix  = mem_rd_data[PW-1:0];
    assign mid_pix = mem_rd_data[MEMW-1:PW];

    // read on accept, write back when the pixel leaves stage 0:
    // middle moves up, the new pixel becomes middle
    lapsh_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (MEMW)
    ) u_line_mem (
        .aclk    (aclk),
        .rd_en   (s_take),
        .rd_addr (col_reg),
        .rd_data (mem_rd_data),
        .wr_en   (s0_adv),
        .wr_addr (s0_col_reg),
        .wr_data ({s0_pix_reg, mid_pix})
    );

    // ---------------- window taps: columns c-2 and c-1 ----------------
    // taps 0..2 = column c-2 (upper, middle, current), taps 3..5 = column c-1
    logic [5:0][PW-1:0] taps_reg;

    always_ff @(posedge aclk) begin
        if (s0_adv) begin
            taps_reg[0] <= taps_reg[3];
            taps_reg[1] <= taps_reg[4];
            taps_reg[2] <= taps_reg[5];
            taps_reg[3] <= up_pix;
            taps_reg[4] <= mid_pix;
            taps_reg[5] <= s0_pix_reg;
        end
    end

    // ---------------- filter pipe ----------------
    lapsh_pkg::win_t win;
    lapsh_pkg::res_t res;
    logic [CW-1:0]   col_m1;

    assign col_m1 = s0_col_reg - CW'(1);

    always_comb begin
        win.pix[0] = taps_reg[0];
        win.pix[1] = taps_reg[1];
        win.pix[2] = taps_reg[2];
        win.pix[3] = taps_reg[3];
        win.pix[4] = taps_reg[4];     // centre
        win.pix[5] = taps_reg[5];
        win.pix[6] = up_pix;
        win.pix[7] = mid_pix;
        win.pix[8] = s0_pix_reg;
        win.row    = s0_row_reg - RW'(1);
        win.col    = lapsh_pkg::COL_W'(col_m1);
        win.last   = s0_last_reg;
    end

    lapsh_filter u_filter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s0_valid_reg && s0_emit_reg),
        .in_ready  (flt_ready),
        .in_win    (win),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {6'd0, res.centre_col, res.centre_row, res.sharpened,
                      res.laplacian_value, res.box_average};
    assign m_tlast = res.frame_last;

    // ---------------- checks ----------------
    // the raster counter never passes the row end
    a_col_in_row : assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= last_col)
        else $error("column counter beyond row end");

    // a read and a write back to the same column never meet in one cycle
    a_no_same_col : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_take && s0_adv) |-> (col_reg != s0_col_reg))
        else $error("line store read and write collide");

    // only interior centres reach the output
    a_interior : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res.centre_row != '0 && res.centre_col != '0))
        else $error("border centre emitted");

endmodule

`default_nettype wire
